### hdl/spef_pkg.sv
// Shared constants for the scanline polygon edge-fill block.
// Used by the divider, the edge table, the top level and its checker.
package spef_pkg;

   // Coordinate and fixed-point widths.
   localparam int X_W    = 9;
   localparam int FRAC_W = 16;
   localparam int QUO_W  = X_W + FRAC_W;
   localparam int ACC_W  = QUO_W + 1;

   // Largest x coordinate; this is also the empty value of a left entry.
   localparam logic [X_W-1:0] X_MAX = 9'd511;

   // Operation codes of an input transaction.
   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_ADD   = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

endpackage

### hdl/spef_div.sv
// Iterative restoring divider that produces the edge slope magnitude.
// One quotient bit per cycle; depends on spef_pkg.
module spef_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [spef_pkg::QUO_W-1:0] num,
   input  logic [spef_pkg::X_W-1:0]   den,
   output logic                      done,
   output logic [spef_pkg::QUO_W-1:0] quot
);

   localparam int CNT_W = $clog2(spef_pkg::QUO_W + 1);

   logic [spef_pkg::QUO_W-1:0] quo_ff, quo_in;
   logic [spef_pkg::X_W-1:0]   rem_ff, rem_in;
   logic [spef_pkg::X_W-1:0]   den_ff, den_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [spef_pkg::X_W:0]     rem_sh;
   logic [spef_pkg::X_W+1:0]   diff;
   logic                       ge;

   // One restoring step: shift in the next dividend bit and try to subtract.
   // The divisor is captured at start, since the input side moves on.
   always_comb begin
      rem_sh = {rem_ff, quo_ff[spef_pkg::QUO_W-1]};
      diff   = {1'b0, rem_sh} - {2'b00, den_ff};
      ge     = ~diff[spef_pkg::X_W+1];
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = CNT_W'(spef_pkg::QUO_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[spef_pkg::QUO_W-2:0], ge};
         rem_in = ge ? diff[spef_pkg::X_W-1:0] : rem_sh[spef_pkg::X_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state is reset; the datapath is not.
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

### hdl/spef_table.sv
// Per-row left and right edge tables, one write and one read port each.
// Read data is registered; depends on spef_pkg.
module spef_table #(
   parameter int ROWS = 512
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] wr_addr,
   input  logic [spef_pkg::X_W-1:0]             wr_left,
   input  logic [spef_pkg::X_W-1:0]             wr_right,
   input  logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] rd_addr,
   output logic [spef_pkg::X_W-1:0]             rd_left,
   output logic [spef_pkg::X_W-1:0]             rd_right
);

   logic [spef_pkg::X_W-1:0] left_table_ff  [ROWS];
   logic [spef_pkg::X_W-1:0] right_table_ff [ROWS];
   logic [spef_pkg::X_W-1:0] rd_left_ff;
   logic [spef_pkg::X_W-1:0] rd_right_ff;

   // Both tables share the address of each port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         left_table_ff[wr_addr]  <= wr_left;
         right_table_ff[wr_addr] <= wr_right;
      end
      rd_left_ff  <= left_table_ff[rd_addr];
      rd_right_ff <= right_table_ff[rd_addr];
   end

   assign rd_left  = rd_left_ff;
   assign rd_right = rd_right_ff;

endmodule

### hdl/scanline_polygon_edge_fill.sv
// Scanline polygon fill, edge-table stage: clears, widens and reads row spans.
// Instantiates spef_div and spef_table; depends on spef_pkg.
//
// The block takes one transaction at a time and holds req_stall high while it works.
// After reset, and after every clear transaction, a clearing pass writes one row a
// cycle through all ROWS rows before the next transaction is taken. A read reads the
// table, then waits while an earlier result is still held by rsp_stall. A horizontal
// edge walks its single row. Any other edge starts the shared one-bit-per-cycle slope
// divider, sets up the walk, and then handles each of the dy + 1 rows walked with a
// table read, then a compare and write, where dy is the row span of the edge. Result
// transactions sit in an output register, so a waiting result does not hold up edge
// or clear work.
module scanline_polygon_edge_fill #(
   parameter int ROWS = 512
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_op,
   input  logic [spef_pkg::X_W-1:0]   req_xa,
   input  logic [spef_pkg::X_W-1:0]   req_ya,
   input  logic [spef_pkg::X_W-1:0]   req_xb,
   input  logic [spef_pkg::X_W-1:0]   req_yb,
   input  logic [spef_pkg::X_W-1:0]   req_row,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [spef_pkg::X_W-1:0]   rsp_span_row,
   output logic [spef_pkg::X_W-1:0]   rsp_span_left,
   output logic [spef_pkg::X_W-1:0]   rsp_span_right,
   output logic                       rsp_span_empty
);

   localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int RW = (AW > spef_pkg::X_W) ? AW : spef_pkg::X_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_DIV,
      ST_WALK_RD,
      ST_WALK_WR,
      ST_READ,
      ST_RESP
   } state_type;

   state_type                  state_ff, state_in;
   logic [spef_pkg::X_W-1:0]   row_ff, row_in;
   logic [spef_pkg::X_W-1:0]   rem_ff, rem_in;
   logic [spef_pkg::X_W-1:0]   xlo_ff, xlo_in;
   logic [spef_pkg::X_W-1:0]   xl_ff, xl_in;
   logic [spef_pkg::X_W-1:0]   xr_ff, xr_in;
   logic                       horiz_ff, horiz_in;
   logic                       neg_ff, neg_in;
   logic [AW-1:0]              clr_cnt_ff, clr_cnt_in;
   logic [spef_pkg::ACC_W-1:0] slope_ff, slope_in;
   logic [spef_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [spef_pkg::X_W-1:0]   rsp_row_ff, rsp_row_in;
   logic [spef_pkg::X_W-1:0]   rsp_left_ff, rsp_left_in;
   logic [spef_pkg::X_W-1:0]   rsp_right_ff, rsp_right_in;
   logic                       rsp_empty_ff, rsp_empty_in;

   logic                       req_accept;
   logic                       swap;
   logic [spef_pkg::X_W-1:0]   ord_xlo, ord_xhi, ord_ylo, ord_yhi;
   logic [spef_pkg::X_W:0]     dx;
   logic [spef_pkg::X_W-1:0]   dx_mag;
   logic                       div_start;
   logic                       div_done;
   logic [spef_pkg::QUO_W-1:0] div_quot;
   logic [spef_pkg::ACC_W-1:0] slope_mag;
   logic [RW-1:0]              row_ext;
   logic [AW-1:0]              row_addr;
   logic                       row_ok;
   logic [spef_pkg::X_W-1:0]   walk_x;
   logic [spef_pkg::X_W-1:0]   upd_l, upd_r;
   logic [spef_pkg::X_W-1:0]   new_left, new_right;
   logic [spef_pkg::X_W-1:0]   rd_left, rd_right;
   logic [spef_pkg::X_W-1:0]   out_left, out_right;
   logic                       wr_en;
   logic [AW-1:0]              wr_addr;
   logic [spef_pkg::X_W-1:0]   wr_left, wr_right;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);

   // Order the endpoints so the walk runs from the lower row to the upper row.
   always_comb begin
      swap    = (req_ya > req_yb);
      ord_xlo = swap ? req_xb : req_xa;
      ord_ylo = swap ? req_yb : req_ya;
      ord_xhi = swap ? req_xa : req_xb;
      ord_yhi = swap ? req_ya : req_yb;
      dx      = {1'b0, ord_xhi} - {1'b0, ord_xlo};
      dx_mag  = dx[spef_pkg::X_W] ? spef_pkg::X_W'(-dx) : dx[spef_pkg::X_W-1:0];
   end

   assign div_start = req_accept && (req_op == spef_pkg::OP_ADD) && (ord_ylo != ord_yhi);

   spef_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   ({dx_mag, {spef_pkg::FRAC_W{1'b0}}}),
      .den   (ord_yhi - ord_ylo),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Table addressing and the out-of-range test for the current row.
   always_comb begin
      row_ext  = RW'(row_ff);
      row_addr = row_ext[AW-1:0];
      row_ok   = (32'(row_ff) < 32'(ROWS));
   end

   // Integer x of the walk: truncate the fixed-point accumulator, clamp below zero.
   always_comb begin
      walk_x    = acc_ff[spef_pkg::ACC_W-1] ? '0 : acc_ff[spef_pkg::FRAC_W +: spef_pkg::X_W];
      upd_l     = horiz_ff ? xl_ff : walk_x;
      upd_r     = horiz_ff ? xr_ff : walk_x;
      new_left  = (upd_l < rd_left)  ? upd_l : rd_left;
      new_right = (upd_r > rd_right) ? upd_r : rd_right;
   end

   // Table write port: the clearing pass or the edge update.
   always_comb begin
      wr_en    = (state_ff == ST_CLEAR) || ((state_ff == ST_WALK_WR) && row_ok);
      wr_addr  = (state_ff == ST_CLEAR) ? clr_cnt_ff : row_addr;
      wr_left  = (state_ff == ST_CLEAR) ? spef_pkg::X_MAX : new_left;
      wr_right = (state_ff == ST_CLEAR) ? '0 : new_right;
   end

   spef_table #(
      .ROWS (ROWS)
   ) u_table (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_left  (wr_left),
      .wr_right (wr_right),
      .rd_addr  (row_addr),
      .rd_left  (rd_left),
      .rd_right (rd_right)
   );

   // A row beyond the tables reads as empty.
   always_comb begin
      out_left  = row_ok ? rd_left : spef_pkg::X_MAX;
      out_right = row_ok ? rd_right : '0;
      slope_mag = {1'b0, div_quot};
   end

   // Sequencer next-state and datapath register updates.
   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      rem_in       = rem_ff;
      xlo_in       = xlo_ff;
      xl_in        = xl_ff;
      xr_in        = xr_ff;
      horiz_in     = horiz_ff;
      neg_in       = neg_ff;
      clr_cnt_in   = clr_cnt_ff;
      slope_in     = slope_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_row_in   = rsp_row_ff;
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;
      rsp_empty_in = rsp_empty_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_op)
                  spef_pkg::OP_CLEAR: begin
                     clr_cnt_in = '0;
                     state_in   = ST_CLEAR;
                  end
                  spef_pkg::OP_ADD: begin
                     row_in   = ord_ylo;
                     rem_in   = ord_yhi - ord_ylo;
                     xlo_in   = ord_xlo;
                     xl_in    = (ord_xlo < ord_xhi) ? ord_xlo : ord_xhi;
                     xr_in    = (ord_xlo < ord_xhi) ? ord_xhi : ord_xlo;
                     horiz_in = (ord_ylo == ord_yhi);
                     neg_in   = dx[spef_pkg::X_W];
                     state_in = (ord_ylo == ord_yhi) ? ST_WALK_RD : ST_DIV;
                  end
                  spef_pkg::OP_READ: begin
                     row_in   = req_row;
                     state_in = ST_READ;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == AW'(ROWS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               slope_in = neg_ff ? -slope_mag : slope_mag;
               acc_in   = {1'b0, xlo_ff, {spef_pkg::FRAC_W{1'b0}}};
               state_in = ST_WALK_RD;
            end
         end
         ST_WALK_RD: begin
            // Rows only grow along the walk, so the first row past the tables ends it.
            state_in = row_ok ? ST_WALK_WR : ST_IDLE;
         end
         ST_WALK_WR: begin
            if (rem_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               row_in   = row_ff + 1'b1;
               rem_in   = rem_ff - 1'b1;
               acc_in   = acc_ff + slope_ff;
               state_in = ST_WALK_RD;
            end
         end
         ST_READ: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = row_ff;
               rsp_left_in  = out_left;
               rsp_right_in = out_right;
               rsp_empty_in = (out_left > out_right);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs; reset starts a clearing pass.
   always_ff @(posedge clock) begin
      row_ff       <= row_in;
      rem_ff       <= rem_in;
      xlo_ff       <= xlo_in;
      xl_ff        <= xl_in;
      xr_ff        <= xr_in;
      horiz_ff     <= horiz_in;
      neg_ff       <= neg_in;
      slope_ff     <= slope_in;
      acc_ff       <= acc_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
      rsp_empty_ff <= rsp_empty_in;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_span_row   = rsp_row_ff;
   assign rsp_span_left  = rsp_left_ff;
   assign rsp_span_right = rsp_right_ff;
   assign rsp_span_empty = rsp_empty_ff;

endmodule

### hdl/spef_checker.sv
// Port-level checks for scanline_polygon_edge_fill, attached with a bind.
// Depends on spef_pkg.
module spef_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic [1:0]               req_op,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic [spef_pkg::X_W-1:0] rsp_span_row,
   input logic [spef_pkg::X_W-1:0] rsp_span_left,
   input logic [spef_pkg::X_W-1:0] rsp_span_right,
   input logic                     rsp_span_empty
);

   // A stalled result transaction holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_span_row)
         && $stable(rsp_span_left) && $stable(rsp_span_right))
      else $error("result transaction changed while stalled");

   // The empty flag agrees with the span it comes with.
   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_span_empty == (rsp_span_left > rsp_span_right)))
      else $error("span_empty does not match left and right");

   // Reset starts the clearing pass, during which nothing is taken.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("input taken right after reset");

   // An accepted clear transaction starts a clearing pass.
   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_op == spef_pkg::OP_CLEAR) |=> req_stall)
      else $error("no clearing pass after a clear transaction");

endmodule

bind scanline_polygon_edge_fill spef_checker u_spef_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_op         (req_op),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_span_row   (rsp_span_row),
   .rsp_span_left  (rsp_span_left),
   .rsp_span_right (rsp_span_right),
   .rsp_span_empty (rsp_span_empty)
);

### tb/tb.sv
// Self-checking testbench for the scanline polygon edge-fill block.
// Holds a span scoreboard class and the top module tb; depends on spef_pkg
// and scanline_polygon_edge_fill.

// One returned row span, as the result channel carries it.
typedef struct packed {
   logic [spef_pkg::X_W-1:0] row;
   logic [spef_pkg::X_W-1:0] left_x;
   logic [spef_pkg::X_W-1:0] right_x;
   logic                     empty;
} span_type;

// Keeps its own left and right edge tables and the spans still owed by the block.
class span_scoreboard;
   int rows;
   logic [spef_pkg::X_W-1:0] left_tab [];
   logic [spef_pkg::X_W-1:0] right_tab [];
   span_type owed_spans [$];
   int errors;
   int reports;
   int edges_seen;
   int flat_seen;
   int clears_seen;
   int reads_checked;
   int empty_checked;

   function new(int table_rows);
      rows = table_rows;
      left_tab = new[table_rows];
      right_tab = new[table_rows];
      clear_tables();
   endfunction

   function void clear_tables();
      for (int i = 0; i < rows; i++) begin
         left_tab[i] = spef_pkg::X_MAX;
         right_tab[i] = '0;
      end
   endfunction

   // Widen one row's span by an x coordinate.
   function void widen_row(int r, int x);
      if (r >= rows) return;
      if (x > int'(spef_pkg::X_MAX)) x = int'(spef_pkg::X_MAX);
      if (x < int'(left_tab[r])) left_tab[r] = x[spef_pkg::X_W-1:0];
      if (x > int'(right_tab[r])) right_tab[r] = x[spef_pkg::X_W-1:0];
   endfunction

   // Walk an edge from its lower row to its upper row in Q10.16 steps.
   function void walk_edge(int xa, int ya, int xb, int yb);
      int xl, yl, xh, yh, dy, slope, xrow;
      longint acc;
      if (ya > yb) begin
         xl = xb; yl = yb; xh = xa; yh = ya;
      end else begin
         xl = xa; yl = ya; xh = xb; yh = yb;
      end
      // A horizontal edge updates its row from both endpoints.
      if (yl == yh) begin
         flat_seen++;
         widen_row(yl, xl);
         widen_row(yl, xh);
         return;
      end
      dy = yh - yl;
      slope = ((xh - xl) * 65536) / dy;
      for (int k = 0; k <= dy; k++) begin
         acc = longint'(xl) * 65536 + longint'(k) * longint'(slope);
         xrow = (acc < 0) ? 0 : int'(acc >>> spef_pkg::FRAC_W);
         widen_row(yl + k, xrow);
      end
   endfunction

   // Apply one accepted input transaction and note the span it owes, if any.
   function void note_request(logic [1:0] op, logic [spef_pkg::X_W-1:0] xa,
                              logic [spef_pkg::X_W-1:0] ya, logic [spef_pkg::X_W-1:0] xb,
                              logic [spef_pkg::X_W-1:0] yb, logic [spef_pkg::X_W-1:0] row);
      span_type s;
      case (op)
         spef_pkg::OP_CLEAR: begin
            clears_seen++;
            clear_tables();
         end
         spef_pkg::OP_ADD: begin
            edges_seen++;
            walk_edge(int'(xa), int'(ya), int'(xb), int'(yb));
         end
         spef_pkg::OP_READ: begin
            s.row = row;
            s.left_x = spef_pkg::X_MAX;
            s.right_x = '0;
            if (int'(row) < rows) begin
               s.left_x = left_tab[row];
               s.right_x = right_tab[row];
            end
            s.empty = (s.left_x > s.right_x);
            owed_spans.push_back(s);
         end
         default: ;
      endcase
   endfunction

   function void report(string what, int want, int got);
      errors++;
      if (reports < 40)
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      reports++;
   endfunction

   // Compare one accepted result transaction with the oldest owed span.
   function void check_span(span_type got);
      span_type want;
      if (owed_spans.size() == 0) begin
         errors++;
         if (reports < 40)
            $display("%0t: unexpected span, expected none, actual row %0d left %0d right %0d",
                     $time, got.row, got.left_x, got.right_x);
         reports++;
         return;
      end
      want = owed_spans.pop_front();
      reads_checked++;
      if (want.empty) empty_checked++;
      if (got.row !== want.row) report("span_row", want.row, got.row);
      if (got.left_x !== want.left_x) report("span_left", want.left_x, got.left_x);
      if (got.right_x !== want.right_x) report("span_right", want.right_x, got.right_x);
      if (got.empty !== want.empty) report("span_empty", want.empty, got.empty);
   endfunction

   function int pending();
      return owed_spans.size();
   endfunction

   // Spans still owed at the end of the run are failures.
   function void close_out();
      if (owed_spans.size() != 0) begin
         errors += owed_spans.size();
         $display("%0t: %0d spans never arrived, expected first row %0d, actual none",
                  $time, owed_spans.size(), owed_spans[0].row);
      end
   endfunction
endclass

module tb;

   localparam int ROWS = 512;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int IDLE_LIMIT = 20000;
   localparam int ITEM_TARGET = 1600;
   localparam int SETTLE_CYCLES = 1100;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_op = spef_pkg::OP_CLEAR;
   logic [spef_pkg::X_W-1:0] req_xa = '0;
   logic [spef_pkg::X_W-1:0] req_ya = '0;
   logic [spef_pkg::X_W-1:0] req_xb = '0;
   logic [spef_pkg::X_W-1:0] req_yb = '0;
   logic [spef_pkg::X_W-1:0] req_row = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [spef_pkg::X_W-1:0] rsp_span_row;
   logic [spef_pkg::X_W-1:0] rsp_span_left;
   logic [spef_pkg::X_W-1:0] rsp_span_right;
   logic rsp_span_empty;

   span_scoreboard spans = new(ROWS);
   int burst_left = 0;
   int max_gap = 8;
   int items_sent = 0;

   scanline_polygon_edge_fill #(.ROWS(ROWS)) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op(req_op),
      .req_xa(req_xa),
      .req_ya(req_ya),
      .req_xb(req_xb),
      .req_yb(req_yb),
      .req_row(req_row),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_span_row(rsp_span_row),
      .rsp_span_left(rsp_span_left),
      .rsp_span_right(rsp_span_right),
      .rsp_span_empty(rsp_span_empty)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Monitor both channels at the clock edge and feed the scoreboard.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            spans.note_request(req_op, req_xa, req_ya, req_xb, req_yb, req_row);
         if (rsp_valid && !rsp_stall)
            spans.check_span({rsp_span_row, rsp_span_left, rsp_span_right, rsp_span_empty});
      end
   end

   // Receiver stall pattern: it switches among four randomly picked stall modes.
   always @(posedge clock) begin
      static int tick = 0;
      static int stall_mode = 0;
      static int hold = 0;
      tick++;
      if (tick % 300 == 0) stall_mode = $urandom_range(0, 3);
      if (hold > 0) hold--;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 1) == 1);
         2: begin
            if (hold == 0) hold = $urandom_range(1, 30);
            rsp_stall <= (hold > 10);
         end
         default: rsp_stall <= ($urandom_range(0, 7) == 0);
      endcase
   end

   // Watchdog: end the run after too many cycles with no transaction on either side.
   initial begin
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle = 0;
         else
            idle++;
      end
      $display("%0t: watchdog, %0d cycles without a transaction", $time, IDLE_LIMIT);
      $display("tb: done, errors");
      $finish;
   end

   // Send one input transaction, idling between bursts, and wait until it is taken.
   task automatic issue(input logic [1:0] op, input logic [spef_pkg::X_W-1:0] xa,
                        input logic [spef_pkg::X_W-1:0] ya, input logic [spef_pkg::X_W-1:0] xb,
                        input logic [spef_pkg::X_W-1:0] yb, input logic [spef_pkg::X_W-1:0] row);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, max_gap)) @(posedge clock);
         if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(40, 120);
         else burst_left = $urandom_range(1, 12);
         max_gap = ($urandom_range(0, 2) == 0) ? 3 : 15;
      end
      burst_left--;
      req_valid <= 1'b1;
      req_op <= op;
      req_xa <= xa;
      req_ya <= ya;
      req_xb <= xb;
      req_yb <= yb;
      req_row <= row;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (op != OP_UNUSED) items_sent++;
   endtask

   // Hold the sender off until every owed span has been returned.
   task automatic drain_pause();
      req_valid <= 1'b0;
      @(posedge clock);
      while (spans.pending() != 0) @(posedge clock);
      burst_left = $urandom_range(1, 30);
   endtask

   // Any coordinate, for fields the block ignores.
   function automatic logic [spef_pkg::X_W-1:0] any_x();
      return spef_pkg::X_W'($urandom);
   endfunction

   function automatic logic [spef_pkg::X_W-1:0] pick_x();
      int r;
      r = $urandom_range(0, 7);
      if (r == 0) return '0;
      if (r == 1) return spef_pkg::X_MAX;
      return spef_pkg::X_W'($urandom_range(0, 511));
   endfunction

   // A polygon: optional clear, a closed ring of edges, then reads, mostly of its rows.
   task automatic polygon_scene();
      int n, base, height, pick;
      logic [spef_pkg::X_W-1:0] vx [6];
      logic [spef_pkg::X_W-1:0] vy [6];
      if ($urandom_range(0, 2) == 0)
         issue(spef_pkg::OP_CLEAR, any_x(), any_x(), any_x(), any_x(), any_x());
      height = ($urandom_range(0, 19) == 0) ? $urandom_range(32, 511) : $urandom_range(0, 24);
      base = $urandom_range(0, 511 - height);
      n = $urandom_range(3, 6);
      for (int k = 0; k < n; k++) begin
         vx[k] = pick_x();
         vy[k] = spef_pkg::X_W'(base + $urandom_range(0, height));
      end
      for (int k = 0; k < n; k++)
         issue(spef_pkg::OP_ADD, vx[k], vy[k], vx[(k + 1) % n], vy[(k + 1) % n], any_x());
      repeat ($urandom_range(3, 10)) begin
         pick = ($urandom_range(0, 3) != 0) ? base + $urandom_range(0, height)
                                            : $urandom_range(0, 511);
         issue(spef_pkg::OP_READ, any_x(), any_x(), any_x(), any_x(), spef_pkg::X_W'(pick));
      end
   endtask

   // Loose transactions: any op code, mostly short edges, random unused fields.
   task automatic noise_item();
      int r, ya, yb;
      r = $urandom_range(0, 99);
      ya = $urandom_range(0, 511);
      yb = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511)
                                       : ya + $urandom_range(0, 16) - 8;
      if (yb < 0) yb = 0;
      if (yb > 511) yb = 511;
      if (r < 4)
         issue(spef_pkg::OP_CLEAR, any_x(), any_x(), any_x(), any_x(), any_x());
      else if (r < 12)
         issue(OP_UNUSED, any_x(), any_x(), any_x(), any_x(), any_x());
      else if (r < 55)
         issue(spef_pkg::OP_ADD, pick_x(), spef_pkg::X_W'(ya), pick_x(),
               spef_pkg::X_W'(yb), any_x());
      else
         issue(spef_pkg::OP_READ, any_x(), any_x(), any_x(), any_x(),
               spef_pkg::X_W'($urandom_range(0, 511)));
   endtask

   // Main stimulus: reset, directed cases, random scenes, then drain and verdict.
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Freshly reset tables read empty at both ends.
      issue(spef_pkg::OP_READ, 0, 0, 0, 0, 0);
      issue(spef_pkg::OP_READ, 0, 0, 0, 0, 511);
      // Unused op code with every field at its top value.
      issue(OP_UNUSED, 511, 511, 511, 511, 511);
      // Horizontal edge, then its row.
      issue(spef_pkg::OP_ADD, 100, 7, 40, 7, 0);
      issue(spef_pkg::OP_READ, 0, 0, 0, 0, 7);
      // Full-height diagonal across the whole table.
      issue(spef_pkg::OP_ADD, 0, 0, 511, 511, 0);
      // Endpoints given top first, negative slope.
      issue(spef_pkg::OP_ADD, 3, 400, 500, 20, 0);
      issue(spef_pkg::OP_READ, 0, 0, 0, 0, 0);
      issue(spef_pkg::OP_READ, 0, 0, 0, 0, 511);
      issue(spef_pkg::OP_READ, 0, 0, 0, 0, 20);
      issue(spef_pkg::OP_READ, 0, 0, 0, 0, 400);
      issue(spef_pkg::OP_READ, 0, 0, 0, 0, 255);
      // Horizontal edge on the last row spanning all x.
      issue(spef_pkg::OP_ADD, 511, 511, 0, 511, 0);
      issue(spef_pkg::OP_READ, 0, 0, 0, 0, 511);
      issue(OP_UNUSED, 0, 0, 0, 0, 0);
      // Clear, then confirm the table is empty again.
      issue(spef_pkg::OP_CLEAR, 0, 0, 0, 0, 0);
      issue(spef_pkg::OP_READ, 0, 0, 0, 0, 255);
      // Single-step edge spanning all x, and a vertical edge.
      issue(spef_pkg::OP_ADD, 0, 0, 511, 1, 0);
      issue(spef_pkg::OP_ADD, 300, 10, 300, 30, 0);
      issue(spef_pkg::OP_READ, 0, 0, 0, 0, 0);
      issue(spef_pkg::OP_READ, 0, 0, 0, 0, 1);
      issue(spef_pkg::OP_READ, 0, 0, 0, 0, 20);
      drain_pause();

      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 3) != 0) begin
            polygon_scene();
            if ($urandom_range(0, 14) == 0) drain_pause();
         end else begin
            repeat ($urandom_range(2, 8)) noise_item();
         end
      end
      req_valid <= 1'b0;

      while (spans.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      spans.close_out();

      $display("tb: %0d transactions sent: %0d edges (%0d horizontal), %0d clears",
               items_sent, spans.edges_seen, spans.flat_seen, spans.clears_seen);
      $display("tb: %0d row spans checked, %0d of them empty",
               spans.reads_checked, spans.empty_checked);
      if (spans.errors == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule

### sim.f
hdl/spef_pkg.sv
hdl/spef_div.sv
hdl/spef_table.sv
hdl/scanline_polygon_edge_fill.sv
hdl/spef_checker.sv
tb/tb.sv
